>>> hw/rtl/postfix_expression_evaluator_top_defines.svh
// assertion macros for the postfix evaluator rtl
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define PED_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define PED_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ped_pkg.sv
// shared types and constants for the postfix evaluator
package ped_pkg;

  localparam int WORD_W = 32;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 3;

  // ascii codes of interest
  localparam logic [SYM_W-1:0] CH_END    = 8'h00;
  localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PCT    = 8'h25;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PAREN     = 3'd4;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_out_t;

endpackage

>>> hw/rtl/ped_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module ped_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ped_pkg::WORD_W-1:0]   dividend,
  input  logic [ped_pkg::WORD_W-1:0]   divisor,
  output ped_pkg::div_out_t            div_o
);
  import ped_pkg::*;

  localparam int SW = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic [SW-1:0]     step;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] abs_a;
  logic [WORD_W-1:0] abs_d;

  assign abs_a   = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
  assign abs_d   = divisor[WORD_W-1]  ? (~divisor + WORD_W'(1))  : divisor;
  assign shifted = {rem, quo[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring step on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= abs_a;
      rem   <= '0;
      dvs   <= abs_d;
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], ~trial[WORD_W]};
      rem <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
    end
  end

  assign div_o.done      = done;
  assign div_o.quotient  = neg_q ? (~quo + WORD_W'(1)) : quo;
  assign div_o.remainder = neg_r ? (~rem + WORD_W'(1)) : rem;

endmodule

>>> hw/rtl/postfix_expression_evaluator_top.sv
// postfix expression evaluator: operand stack, sequencer and output register
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------
//   sym     | sym_valid / sym_ready | symbol_byte[7:0]
//   res     | res_valid / res_ready | result_value[31:0], status[2:0]
//
// a digit or ignored word is handled in the idle state; + - * do two stack reads
// through the registered memory port, then the write-back
// / and % do the same reads, then run the 32-step shared divider
// an end word reads the top, then waits for the output register to free up
// sym_ready is low while an operator or end word is in flight
// reset empties the stack and clears the sticky error; stack entries are
// never cleared, only entries below the count are used
`include "postfix_expression_evaluator_top_defines.svh"
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sym_valid,
  output logic                               sym_ready,
  input  logic [ped_pkg::SYM_W-1:0]          symbol_byte,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [ped_pkg::WORD_W-1:0]  result_value,
  output logic [ped_pkg::STAT_W-1:0]         status
);
  import ped_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [STAT_W-1:0] err, err_next;
  logic [STAT_W-1:0] end_st, end_st_next;
  logic [SYM_W-1:0]  op, op_next;
  logic [WORD_W-1:0] rhs, rhs_next;

  // stack memory, one write and one registered read port
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic              re;
  logic [AW-1:0]     ra;
  logic [WORD_W-1:0] rd_data;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic              is_op;
  logic              is_paren;
  logic              div_start;
  logic              out_load;
  div_out_t          div_o;

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign sym_ready = (state == S_IDLE);

  always_comb begin
    is_op    = symbol_byte inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};
    is_paren = symbol_byte inside {CH_LPAREN, CH_RPAREN};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  // shared divider for / and %
  ped_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (rhs),
    .div_o    (div_o)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    err_next    = err;
    end_st_next = end_st;
    op_next     = op;
    rhs_next    = rhs;
    we          = 1'b0;
    wa          = cnt_m2[AW-1:0];
    wd          = '0;
    re          = 1'b0;
    ra          = cnt_m1[AW-1:0];
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_IDLE: begin
        if (sym_valid) begin
          if (symbol_byte == CH_END) begin
            // fetch the top, latch the status, clear for the next expression
            re = 1'b1;
            if (err != ST_OK) begin
              end_st_next = err;
            end else if (count == '0) begin
              end_st_next = ST_UNDERFLOW;
            end else begin
              end_st_next = ST_OK;
            end
            count_next = '0;
            err_next   = ST_OK;
            state_next = S_END;
          end else if (err != ST_OK) begin
            // sticky error: drop the word
          end else if (is_paren) begin
            err_next = ST_PAREN;
          end else if (is_op) begin
            if (count < CW'(2)) begin
              err_next = ST_UNDERFLOW;
            end else begin
              re         = 1'b1;
              op_next    = symbol_byte;
              state_next = S_RD1;
            end
          end else if (count == CW'(STACK_DEPTH)) begin
            err_next = ST_OVERFLOW;
          end else begin
            // plain push of byte minus ascii zero
            we         = 1'b1;
            wa         = count[AW-1:0];
            wd         = WORD_W'(symbol_byte) - WORD_W'(CH_ZERO);
            count_next = count + CW'(1);
          end
        end
      end
      S_RD1: begin
        // right operand arrives, fetch the left one
        rhs_next   = rd_data;
        re         = 1'b1;
        ra         = cnt_m2[AW-1:0];
        state_next = S_RD2;
      end
      S_RD2: begin
        // left operand on rd_data; result lands where the left one was
        state_next = S_IDLE;
        count_next = cnt_m1;
        case (op)
          CH_PLUS: begin
            we = 1'b1;
            wd = rd_data + rhs;
          end
          CH_MINUS: begin
            we = 1'b1;
            wd = rd_data - rhs;
          end
          CH_STAR: begin
            we = 1'b1;
            wd = rd_data * rhs;
          end
          default: begin
            count_next = cnt_m2;
            if (rhs == '0) begin
              err_next = ST_DIVZERO;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_o.done) begin
          we         = 1'b1;
          wa         = count[AW-1:0];
          wd         = (op == CH_SLASH) ? div_o.quotient : div_o.remainder;
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end
      S_END: begin
        // wait for the output register to free up
        if (!res_valid || res_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    end_st <= end_st_next;
    op     <= op_next;
    rhs    <= rhs_next;
  end

  // output register, holds the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= (end_st == ST_OK) ? rd_data : '0;
      status       <= end_st;
    end
  end

  `PED_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(STACK_DEPTH), "stack count past depth")
  `PED_ASSERT_IMP(a_div_done_state, div_o.done, state == S_DIV, "divider done outside div")
  `PED_ASSERT_IMP(a_rd2_operands, state == S_RD2, count >= CW'(2), "operator without two operands")
  `PED_ASSERT_NXT(a_end_clears, sym_valid && sym_ready && symbol_byte == CH_END, state == S_END && count == '0 && err == ST_OK, "end word did not clear stack")

endmodule
